// ===== sv/vector_normalizer_top_defines.svh =====
// assertion macros shared by the vector normalizer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef VECTOR_NORMALIZER_TOP_DEFINES_SVH
`define VECTOR_NORMALIZER_TOP_DEFINES_SVH

// same-cycle implication, checks off while reset is high
`define VN_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checks off while reset is high
`define VN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/vn_pkg.sv =====
// types, constants and microcode table for the vector normalizer
// no dependencies; used by vector_normalizer_top
package vn_pkg;

   localparam int ELEM_W      = 16;
   localparam int SQ_W        = 31;   // square of a q1.15 element, at most 2^30
   localparam int QUO_W       = 33;   // floor(x^2 * 2^32 / q), at most 2^32
   localparam int SRC_W       = 34;   // quotient padded to whole bit pairs
   localparam int ROOT_W      = 17;
   localparam int SREM_W      = 18;
   localparam int STRY_W      = 20;
   localparam int CNT_W       = 6;
   localparam int PC_W        = 4;
   localparam int DIV_STEPS   = 33;
   localparam int SQRT_STEPS  = 17;
   localparam logic [ELEM_W-1:0] POS_MAX = 16'h7fff;
   localparam logic [ROOT_W-1:0] POS_LIM = 17'd32767;

   typedef enum logic [PC_W-1:0] {
      PC_ACCEPT = 4'd0,
      PC_READ   = 4'd1,
      PC_LOAD   = 4'd2,
      PC_SQUARE = 4'd3,
      PC_DINIT  = 4'd4,
      PC_DIV    = 4'd5,
      PC_SINIT  = 4'd6,
      PC_SQRT   = 4'd7,
      PC_EMIT   = 4'd8,
      PC_CLEAR  = 4'd9
   } pc_type;

   typedef enum logic [3:0] {
      OP_ACCEPT,
      OP_NOP,
      OP_LOAD,
      OP_SQUARE,
      OP_DINIT,
      OP_DIV,
      OP_SINIT,
      OP_SQRT,
      OP_EMIT,
      OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {
      WT_NONE,
      WT_ACCEPT,
      WT_COUNT,
      WT_OUT
   } wait_type;

   typedef enum logic [2:0] {
      JC_NONE,
      JC_ALWAYS,
      JC_NOT_LAST,
      JC_ZERO,
      JC_MORE
   } jump_type;

   typedef struct packed {
      op_type   op;
      wait_type wt;
      jump_type jc;
      pc_type   target;
   } ctrl_type;

   // control store: one word per program step
   function automatic ctrl_type ucode(pc_type pc);
      ctrl_type w;
      unique case (pc)
         PC_ACCEPT: w = '{OP_ACCEPT, WT_ACCEPT, JC_NOT_LAST, PC_ACCEPT};
         PC_READ:   w = '{OP_NOP,    WT_NONE,   JC_NONE,     PC_ACCEPT};
         PC_LOAD:   w = '{OP_LOAD,   WT_NONE,   JC_ZERO,     PC_EMIT};
         PC_SQUARE: w = '{OP_SQUARE, WT_NONE,   JC_NONE,     PC_ACCEPT};
         PC_DINIT:  w = '{OP_DINIT,  WT_NONE,   JC_NONE,     PC_ACCEPT};
         PC_DIV:    w = '{OP_DIV,    WT_COUNT,  JC_NONE,     PC_ACCEPT};
         PC_SINIT:  w = '{OP_SINIT,  WT_NONE,   JC_NONE,     PC_ACCEPT};
         PC_SQRT:   w = '{OP_SQRT,   WT_COUNT,  JC_NONE,     PC_ACCEPT};
         PC_EMIT:   w = '{OP_EMIT,   WT_OUT,    JC_MORE,     PC_READ};
         PC_CLEAR:  w = '{OP_CLEAR,  WT_NONE,   JC_ALWAYS,   PC_ACCEPT};
         default:   w = '{OP_CLEAR,  WT_NONE,   JC_ALWAYS,   PC_ACCEPT};
      endcase
      return w;
   endfunction

endpackage

// ===== sv/vector_normalizer_top.sv =====
// vector normalizer: buffers a q1.15 vector and scales it to unit length
// usage: req_ items in one at a time, last_element closes the vector; rsp_ items
// carry one normalized element each, last_result on the final one.
// both channels are valid/ready; an item moves when valid and ready are high.
// while collecting, req_ready is high and one element is taken per cycle.
// after the last element each result goes through one memory read, a
// 16x16 square, a 33-step restoring divide by the sum of squares, a 17-step
// square root and the output load; when the sum is zero the square, divide
// and root are skipped. a single divide unit and a single root unit serve
// every element in turn, and a clearing step closes the vector at the end.
// results go through an output register: a stalled receiver holds the
// sequencer at its emit step until the register frees up, nothing is lost.
// elements past MAX_LEN are dropped and flagged on every result.
// synchronous active-high reset empties the buffer and drops any result
// not yet taken; no clearing pass is needed.
// depends on vn_pkg and vector_normalizer_top_defines.svh
`include "vector_normalizer_top_defines.svh"

module vector_normalizer_top #(
   parameter int MAX_LEN = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_elem_value,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_norm_value,
   output logic        rsp_last_result,
   output logic        rsp_zero_vector,
   output logic        rsp_overflowed
);

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int NUM_W = $clog2(MAX_LEN + 1);
   localparam int SUM_W = vn_pkg::SQ_W + $clog2(MAX_LEN);
   localparam int REM_W = SUM_W + 1;

   // sequencer
   vn_pkg::pc_type   pc_ff;
   vn_pkg::pc_type   pc_in;
   vn_pkg::ctrl_type uc;
   logic [vn_pkg::CNT_W-1:0] cnt_ff;
   logic go;
   logic take;

   // datapath control
   logic accepted;
   logic buffered;
   logic out_free;
   logic emit_go;
   logic sum_zero;
   logic idx_last;

   // storage
   logic [vn_pkg::ELEM_W-1:0] mem [MAX_LEN];
   logic [vn_pkg::ELEM_W-1:0] rd_ff;
   logic [NUM_W-1:0]          count_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [SUM_W-1:0]          sum_ff;
   logic                      ovf_ff;
   logic                      pend_ff;
   logic [vn_pkg::SQ_W-1:0]   sq_ff;
   logic [vn_pkg::ELEM_W-1:0] elem_ff;
   logic                      zero_ff;

   // arithmetic
   logic signed [15:0] mul_a;
   logic signed [31:0] prod;
   logic [REM_W-1:0]   rem_ff;
   logic [REM_W-1:0]   dsor;
   logic [REM_W-1:0]   rdiff;
   logic               dge;
   logic [vn_pkg::QUO_W-1:0]  quo_ff;
   logic [vn_pkg::SRC_W-1:0]  src_ff;
   logic [vn_pkg::SREM_W-1:0] sr_ff;
   logic [vn_pkg::ROOT_W-1:0] root_ff;
   logic [vn_pkg::STRY_W-1:0] shifted;
   logic [vn_pkg::STRY_W-1:0] trial;
   logic                      sge;
   logic [vn_pkg::ROOT_W:0]   rinc;
   logic [vn_pkg::ROOT_W-1:0] mag;
   logic [vn_pkg::ELEM_W-1:0] y;

   // output register
   logic        rsp_valid_ff;
   logic [15:0] rsp_norm_ff;
   logic        rsp_last_ff;
   logic        rsp_zero_ff;
   logic        rsp_ovf_ff;

   assign uc = vn_pkg::ucode(pc_ff);

   // control outputs of the current microword
   always_comb begin
      req_ready = (uc.op == vn_pkg::OP_ACCEPT);
      accepted  = req_ready && req_valid;
      buffered  = count_ff < NUM_W'(MAX_LEN);
      out_free  = !rsp_valid_ff || rsp_ready;
      emit_go   = (uc.op == vn_pkg::OP_EMIT) && out_free;
      sum_zero  = (sum_ff == '0);
      idx_last  = (NUM_W'(idx_ff) + NUM_W'(1)) == count_ff;
   end

   // next step
   always_comb begin
      unique case (uc.wt)
         vn_pkg::WT_NONE:   go = 1'b1;
         vn_pkg::WT_ACCEPT: go = req_valid;
         vn_pkg::WT_COUNT:  go = (cnt_ff == '0);
         vn_pkg::WT_OUT:    go = out_free;
         default:           go = 1'b1;
      endcase
      unique case (uc.jc)
         vn_pkg::JC_NONE:     take = 1'b0;
         vn_pkg::JC_ALWAYS:   take = 1'b1;
         vn_pkg::JC_NOT_LAST: take = !req_last_element;
         vn_pkg::JC_ZERO:     take = sum_zero;
         vn_pkg::JC_MORE:     take = !idx_last;
         default:             take = 1'b0;
      endcase
      priority if (!go) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = uc.target;
      end else begin
         pc_in = vn_pkg::pc_type'(vn_pkg::PC_W'(pc_ff) + vn_pkg::PC_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= vn_pkg::PC_ACCEPT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // step counter for the iterative units
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         unique case (uc.op)
            vn_pkg::OP_DINIT: cnt_ff <= vn_pkg::CNT_W'(vn_pkg::DIV_STEPS - 1);
            vn_pkg::OP_SINIT: cnt_ff <= vn_pkg::CNT_W'(vn_pkg::SQRT_STEPS - 1);
            vn_pkg::OP_DIV,
            vn_pkg::OP_SQRT:  cnt_ff <= (cnt_ff == '0) ? cnt_ff
                                                       : cnt_ff - vn_pkg::CNT_W'(1);
            default:          cnt_ff <= cnt_ff;
         endcase
      end
   end

   // element buffer
   always_ff @(posedge clock) begin
      if (accepted && buffered) begin
         mem[count_ff[IDX_W-1:0]] <= req_elem_value;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[idx_ff];
   end

   // one multiplier squares incoming items and later the element being scaled
   assign mul_a = (uc.op == vn_pkg::OP_ACCEPT) ? $signed(req_elem_value) : $signed(elem_ff);
   assign prod  = mul_a * mul_a;

   always_ff @(posedge clock) begin
      if ((uc.op == vn_pkg::OP_ACCEPT) || (uc.op == vn_pkg::OP_SQUARE)) begin
         sq_ff <= prod[vn_pkg::SQ_W-1:0];
      end
   end

   // vector bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         pend_ff <= accepted && buffered;
         if (uc.op == vn_pkg::OP_CLEAR) begin
            count_ff <= '0;
            sum_ff   <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            // square of the previous item lands in the cycle after it was taken
            if (pend_ff) begin
               sum_ff <= sum_ff + SUM_W'(sq_ff);
            end
            if (accepted) begin
               if (buffered) begin
                  count_ff <= count_ff + NUM_W'(1);
               end else begin
                  ovf_ff <= 1'b1;
               end
            end
         end
         if (emit_go) begin
            idx_ff <= idx_last ? '0 : idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (uc.op == vn_pkg::OP_LOAD) begin
         elem_ff <= rd_ff;
         zero_ff <= sum_zero;
      end
   end

   // restoring divide: floor(x^2 * 2^32 / sum), one quotient bit per step
   assign dsor  = {1'b0, sum_ff};
   assign dge   = rem_ff >= dsor;
   assign rdiff = dge ? (rem_ff - dsor) : rem_ff;

   always_ff @(posedge clock) begin
      unique case (uc.op)
         vn_pkg::OP_DINIT: rem_ff <= REM_W'(sq_ff);
         vn_pkg::OP_DIV: begin
            rem_ff <= {rdiff[REM_W-2:0], 1'b0};
            quo_ff <= {quo_ff[vn_pkg::QUO_W-2:0], dge};
         end
         default: rem_ff <= rem_ff;
      endcase
   end

   // digit-by-digit square root, one bit pair per step
   assign shifted = {sr_ff, src_ff[vn_pkg::SRC_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign sge     = shifted >= trial;

   always_ff @(posedge clock) begin
      unique case (uc.op)
         vn_pkg::OP_SINIT: begin
            src_ff  <= {1'b0, quo_ff};
            sr_ff   <= '0;
            root_ff <= '0;
         end
         vn_pkg::OP_SQRT: begin
            src_ff  <= {src_ff[vn_pkg::SRC_W-3:0], 2'b00};
            sr_ff   <= sge ? vn_pkg::SREM_W'(shifted - trial) : shifted[vn_pkg::SREM_W-1:0];
            root_ff <= {root_ff[vn_pkg::ROOT_W-2:0], sge};
         end
         default: root_ff <= root_ff;
      endcase
   end

   // halve with rounding, restore sign, saturate; a zero-sum vector passes its elements through
   always_comb begin
      rinc = {1'b0, root_ff} + (vn_pkg::ROOT_W + 1)'(1);
      mag  = rinc[vn_pkg::ROOT_W:1];
      priority if (zero_ff) begin
         y = elem_ff;
      end else if (elem_ff[vn_pkg::ELEM_W-1]) begin
         y = vn_pkg::ELEM_W'(vn_pkg::ROOT_W'(0) - mag);
      end else if (mag > vn_pkg::POS_LIM) begin
         y = vn_pkg::POS_MAX;
      end else begin
         y = mag[vn_pkg::ELEM_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_norm_ff <= y;
         rsp_last_ff <= idx_last;
         rsp_zero_ff <= zero_ff;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_norm_value  = rsp_norm_ff;
   assign rsp_last_result = rsp_last_ff;
   assign rsp_zero_vector = rsp_zero_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

   `VN_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
      count_ff <= NUM_W'(MAX_LEN), "count past buffer size")
   `VN_ASSERT_IMPL(a_ovf_full, clock, reset, ovf_ff,
      count_ff == NUM_W'(MAX_LEN), "overflow with room left")
   `VN_ASSERT_IMPL(a_idle_idx, clock, reset, pc_ff == vn_pkg::PC_ACCEPT,
      idx_ff == '0, "collecting mid-emit")
   `VN_ASSERT_NEXT(a_div_done, clock, reset, (pc_ff == vn_pkg::PC_DIV) && (cnt_ff == '0),
      pc_ff == vn_pkg::PC_SINIT, "divide did not hand off")
   `VN_ASSERT_NEXT(a_emit_load, clock, reset, emit_go, rsp_valid_ff, "emit step lost its item")

endmodule

// ===== tb/vector_normalizer_top_tb.sv =====
// self-checking testbench for vector_normalizer_top: directed rows, then random vectors
// results are checked against an in-bench integer predictor of the normalization
// depends only on the vector_normalizer_top rtl
`timescale 1ns / 100ps

module vector_normalizer_top_tb;

   localparam int MAX_LEN      = 16;
   localparam int IDLE_PCT     = 22;
   localparam int RANDOM_ITEMS = 84;
   localparam int HOLD_AT      = 40;    // results taken before the long receiver hold-off
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 150;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [15:0] value;
      logic        last;
      logic        zero;
      logic        ovf;
   } norm_result_type;

   typedef struct packed {
      logic [15:0]     elem;
      logic            last;
      logic            typed;   // want holds the result typed in by hand
      norm_result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [15:0] req_elem_value   = 16'h0000;
   logic        req_last_element = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [15:0] rsp_norm_value;
   logic        rsp_last_result;
   logic        rsp_zero_vector;
   logic        rsp_overflowed;

   // predictor state
   logic [15:0]     held_elems [MAX_LEN];
   int              held_count    = 0;
   longint unsigned square_total  = 0;
   bit              elems_dropped = 0;
   norm_result_type pending_norms [$];

   int  mismatches       = 0;
   int  results_seen     = 0;
   int  items_sent       = 0;
   int  vectors_done     = 0;
   int  overflow_vectors = 0;
   int  zero_vectors     = 0;
   bit  req_steady       = 0;

   vector_normalizer_top #(.MAX_LEN(MAX_LEN)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_elem_value   (req_elem_value),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_norm_value   (rsp_norm_value),
      .rsp_last_result  (rsp_last_result),
      .rsp_zero_vector  (rsp_zero_vector),
      .rsp_overflowed   (rsp_overflowed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results still pending", pending_norms.size());
      $display("vector_normalizer_top_tb NOT OK");
      $finish;
   end

   // floor of the square root, bit by bit from the top
   function automatic longint unsigned int_root(longint unsigned d);
      logic [65:0] root;
      logic [65:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (66'd1 << b);
         if (trial * trial <= {2'b00, d}) root = trial;
      end
      return root[63:0];
   endfunction

   // round(32768 * x / sqrt(q)) ties away from zero, then saturate to 16 bits
   function automatic logic [15:0] scaled_norm(logic [15:0] elem, longint unsigned q);
      int              x;
      int              y;
      longint unsigned mag;
      longint unsigned quot;
      longint unsigned m;
      x    = $signed(elem);
      mag  = (x < 0) ? longint'(-x) : longint'(x);
      mag  = mag * 32768;
      // the root of 4*t^2/q is twice the ideal value, so halving rounds it
      quot = (4 * mag * mag) / q;
      m    = (int_root(quot) + 1) / 2;
      if (x < 0) begin
         if (m > 32768) m = 32768;
         y = -int'(m);
      end else begin
         if (m > 32767) m = 32767;
         y = int'(m);
      end
      return y[15:0];
   endfunction

   task automatic absorb_element(stim_row_type row);
      norm_result_type r;
      int              x;
      if (held_count < MAX_LEN) begin
         held_elems[held_count] = row.elem;
         held_count++;
         x = $signed(row.elem);
         square_total += longint'(x * x);
      end else begin
         elems_dropped = 1;
      end
      if (row.last) begin
         vectors_done++;
         if (elems_dropped) overflow_vectors++;
         if (square_total == 0) zero_vectors++;
         if (row.typed) begin
            pending_norms.push_back(row.want);
         end else begin
            for (int i = 0; i < held_count; i++) begin
               r.value = (square_total == 0) ? held_elems[i]
                                             : scaled_norm(held_elems[i], square_total);
               r.last  = (i == held_count - 1);
               r.zero  = (square_total == 0);
               r.ovf   = elems_dropped;
               pending_norms.push_back(r);
            end
         end
         held_count    = 0;
         square_total  = 0;
         elems_dropped = 0;
      end
   endtask

   // offer one item, with an occasional gap first, and wait for it to be taken
   task automatic send_item(stim_row_type row);
      if (!req_steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_elem_value   <= row.elem;
      req_last_element <= row.last;
      do @(posedge clock); while (!req_ready);
      absorb_element(row);
      items_sent++;
   endtask

   function automatic stim_row_type mk_row(logic [15:0] e, logic l, logic typed = 1'b0,
                                           logic [15:0] v = 16'h0000, logic z = 1'b0);
      stim_row_type row;
      row.elem  = e;
      row.last  = l;
      row.typed = typed;
      row.want  = typed ? {v, 1'b1, z, 1'b0} : '0;
      return row;
   endfunction

   function automatic logic [15:0] rand_elem();
      case ($urandom_range(9))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'($urandom_range(0, 31)) - 16'd16;
         default: return 16'($urandom);
      endcase
   endfunction

   // stimulus and prediction
   initial begin
      stim_row_type plan [$];
      stim_row_type row;
      int           random_items;
      int           kind;
      int           len;
      random_items = 0;

      // nonzero single-element vectors land on full scale whatever their size; a zero one passes through
      plan.push_back(mk_row(16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1));
      plan.push_back(mk_row(16'h7fff, 1'b1, 1'b1, 16'h7fff));
      plan.push_back(mk_row(16'h8000, 1'b1, 1'b1, 16'h8000));
      plan.push_back(mk_row(16'h0001, 1'b1, 1'b1, 16'h7fff));
      plan.push_back(mk_row(16'hffff, 1'b1, 1'b1, 16'h8000));
      // zero vector of two, then a 3-4-5 triangle
      plan.push_back(mk_row(16'h0000, 1'b0));
      plan.push_back(mk_row(16'h0000, 1'b1));
      plan.push_back(mk_row(16'd3, 1'b0));
      plan.push_back(mk_row(16'd4, 1'b1));
      // fill the buffer; the closing element is dropped but still ends the vector
      for (int k = 0; k < MAX_LEN; k++)
         plan.push_back(mk_row((k == 0) ? 16'h8000 : (k == 1) ? 16'h7fff
                                : 16'(k * 3001 - 20000), 1'b0));
      plan.push_back(mk_row(16'h1234, 1'b1));

      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (plan[i]) send_item(plan[i]);

      while (random_items < RANDOM_ITEMS) begin
         kind = $urandom_range(19);
         if (kind == 0)      len = $urandom_range(1, 4);
         else if (kind == 1) len = $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
         else if (kind == 2) len = MAX_LEN;
         else                len = $urandom_range(1, 6);
         for (int k = 0; k < len; k++) begin
            row = mk_row((kind == 0) ? 16'h0000 : rand_elem(), k == len - 1);
            req_steady = (random_items >= 30 && random_items < 60);
            send_item(row);
            random_items++;
         end
      end
      req_valid <= 1'b0;

      while (pending_norms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items in %0d vectors (%0d overflowed, %0d all zero), %0d results checked",
               items_sent, vectors_done, overflow_vectors, zero_vectors, results_seen);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("vector_normalizer_top_tb OK");
      end else begin
         $display("vector_normalizer_top_tb NOT OK");
      end
      $finish;
   end

   // result checking
   initial begin
      norm_result_type got;
      norm_result_type want;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_norm_value, rsp_last_result, rsp_zero_vector, rsp_overflowed};
            results_seen++;
            if (pending_norms.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: value %h last %b zero %b ovf %b",
                           got.value, got.last, got.zero, got.ovf);
            end else begin
               want = pending_norms.pop_front();
               if (got.value !== want.value || got.last !== want.last ||
                   got.zero !== want.zero || got.ovf !== want.ovf) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"result %0d: expected value %h last %b zero %b ovf %b,",
                               " got value %h last %b zero %b ovf %b"}, results_seen,
                              want.value, want.last, want.zero, want.ovf,
                              got.value, got.last, got.zero, got.ovf);
               end
            end
         end
      end
   end

   // receiver readiness, with one long hold-off so the block fills up and stalls its input
   initial begin
      bit hold_done;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (results_seen >= 60 && results_seen < 90)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/vn_pkg.sv
sv/vector_normalizer_top.sv
tb/vector_normalizer_top_tb.sv
